// ----- rtl/core/ast_pkg.sv -----
package ast_pkg;

  localparam int unsigned MaxKwLen   = 10;
  localparam int unsigned OffBits    = 24;
  localparam int unsigned LineBits   = 16;
  localparam int unsigned LenBits    = 16;
  localparam int unsigned NumKw      = 35;
  localparam int unsigned KwIdxBits  = 6;
  localparam int unsigned KindBits   = 4;
  localparam int unsigned KwLenBits  = $clog2(MaxKwLen + 1);

  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_COMMENT  = 4'd1,
    M_HASH     = 4'd2,
    M_WORD     = 4'd3,
    M_NUMBER   = 4'd4,
    M_NUMDOT   = 4'd5,
    M_FRACTION = 4'd6,
    M_REG      = 4'd7,
    M_LABEL    = 4'd8,
    M_STRING   = 4'd9
  } mode_e;

  typedef enum logic [KindBits-1:0] {
    K_END     = 4'd0,
    K_WORD    = 4'd1,
    K_KEYWORD = 4'd2,
    K_NUMBER  = 4'd3,
    K_REGISTER= 4'd4,
    K_LABEL   = 4'd5,
    K_COMMA   = 4'd6,
    K_STRING  = 4'd7,
    K_ERROR   = 4'd8
  } kind_e;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;

  typedef logic [MaxKwLen*8-1:0] kw_text_t;

  typedef struct packed {
    kind_e                 kind;
    logic [KwIdxBits-1:0]  kw;
    logic [OffBits-1:0]    start;
    logic [LenBits-1:0]    len;
    logic [LineBits-1:0]   line;
    logic                  last;
  } token_t;

  // Input item: one source byte plus the end-of-source flag.
  typedef struct packed {
    logic [7:0] char_in;
    logic       source_end;
  } src_item_t;

  // Result item as it appears on the output channel.
  typedef struct packed {
    logic [KindBits-1:0]   token_kind;
    logic [KwIdxBits-1:0]  keyword_index;
    logic [OffBits-1:0]    start_offset;
    logic [LenBits-1:0]    token_length;
    logic [LineBits-1:0]   line_number;
    logic                  last_of_run;
  } tok_item_t;

  // Keyword text as a string literal: first character in the highest used byte.
  function automatic kw_text_t kw_text(input int unsigned i);
    logic [8*MaxKwLen-1:0] s;
    s = '0;
    case (i)
      0:  s = "nop";        1:  s = "exit";      2:  s = "peek";
      3:  s = "poke";       4:  s = "memcpy";    5:  s = "goto";
      6:  s = "jmpz";       7:  s = "jmpnz";     8:  s = "pop";
      9:  s = "ret";        10: s = "call";      11: s = "push";
      12: s = "or";         13: s = "xor";       14: s = "add";
      15: s = "sub";        16: s = "mul";       17: s = "div";
      18: s = "inc";        19: s = "dec";       20: s = "and";
      21: s = "lft";        22: s = "rgt";       23: s = "not";
      24: s = "store";      25: s = "random";    26: s = {"print_", "int"};
      27: s = "int2string"; 28: s = "concat";    29: s = "system";
      30: s = {"print_", "str"};  31: s = "string2int";  32: s = "cmp";
      33: s = {"is_", "string"};  34: s = {"is_", "integer"};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [KwLenBits-1:0] kw_len(input int unsigned i);
    kw_text_t             s;
    logic [KwLenBits-1:0] l;
    s = kw_text(i);
    l = '0;
    for (int b = 0; b < MaxKwLen; b++) begin
      if (s[8*b +: 8] != 8'h00) l = KwLenBits'(b + 1);
    end
    return l;
  endfunction

  // Reverse a string literal so character 0 lands in the low byte.
  function automatic kw_text_t kw_le(input int unsigned i);
    kw_text_t s;
    kw_text_t r;
    int unsigned n;
    s = kw_text(i);
    n = 32'(kw_len(i));
    r = '0;
    for (int b = 0; b < MaxKwLen; b++) begin
      if (b < n) r[8*b +: 8] = s[8*(n-1-b) +: 8];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ast_stream_if.sv -----
interface ast_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/assembly_source_tokenizer.sv -----
// Assembly source tokenizer.
// in_i  : one source byte per item (char_in, source_end). source_end flushes the
//         pending token, adds an end token and restarts offsets and lines.
// out_o : tokens (kind, keyword index, start, length, line, last_of_run).
// One byte gives zero to three tokens. The byte is scanned in the accept
// cycle and its tokens are loaded into a four-entry result register; they
// leave one per cycle while the receiver is ready, from the following cycle on.
// Throughput: one byte per cycle while each byte gives at most one token
// and the receiver is ready; a byte that gives more tokens holds the input
// until only its last token is left, because the result register drains one token per cycle.
// Input is taken whenever the result register will be empty after this
// cycle, so a byte is accepted while the last token still goes out.
// Reset: scanner idle, offset and line count zero, no tokens pending.
// Receiver stall: tokens stay put, and the input stops while any token
// waits that does not leave in this cycle.
// The keyword table compare sits in ast_kw_match.
module assembly_source_tokenizer (
  input  logic clk_i,
  input  logic rst_ni,
  ast_stream_if.sink   in_i,
  ast_stream_if.source out_o
);
  localparam int unsigned OB = ast_pkg::OffBits;
  localparam int unsigned LB = ast_pkg::LineBits;
  localparam int unsigned NB = ast_pkg::LenBits;
  localparam int unsigned KL = ast_pkg::MaxKwLen;

  ast_pkg::mode_e      mode_q, mode_d;
  logic [OB-1:0]       start_q, start_d, pos_q, pos_d;
  logic [NB-1:0]       len_q, len_d;
  logic [LB-1:0]       line_q, line_d;
  logic [KL*8-1:0]     wbuf_q, wbuf_d;
  logic                ovl_q, ovl_d;

  ast_pkg::token_t     tok_q [4];
  ast_pkg::token_t     tok_d [4];
  logic [2:0]          cnt_q, cnt_d;
  logic [1:0]          rd_q, rd_d;

  logic [7:0]          c;
  logic                fire, pop;
  logic [ast_pkg::KwIdxBits-1:0] kw;
  ast_pkg::token_t     nt [4];
  logic [2:0]          n;

  assign c     = in_i.data.char_in;
  assign pop   = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_o.ready);
  assign fire  = in_i.valid && in_i.ready;
  assign out_o.valid = cnt_q != 3'd0;

  ast_kw_match u_kw (.word_i(wbuf_q), .len_i(len_q), .overlong_i(ovl_q), .kw_o(kw));

  function automatic logic is_let(input logic [7:0] x);
    return (x >= 8'h61 && x <= 8'h7a) || (x >= 8'h41 && x <= 8'h5a) || x == 8'h5f;
  endfunction
  function automatic logic is_dig(input logic [7:0] x);
    return x >= 8'h30 && x <= 8'h39;
  endfunction

  always_comb begin
    logic again;
    logic [NB:0] ls;
    logic [OB:0] es;
    mode_d = mode_q; start_d = start_q; pos_d = pos_q; len_d = len_q;
    line_d = line_q; wbuf_d = wbuf_q; ovl_d = ovl_q;
    again = 1'b0; n = '0; ls = '0; es = '0;
    for (int k = 0; k < 4; k++) begin
      nt[k] = '{kind: ast_pkg::K_END, kw: '0, start: '0, len: '0, line: '0, last: 1'b0};
    end
    // Pending-token flush, shared by end of source and by terminated tokens.
    if (in_i.data.source_end) again = 1'b1;
    else begin
      unique case (mode_q)
        ast_pkg::M_COMMENT:
          if (c == ast_pkg::ChLf) begin
            if (line_d != '1) line_d = line_d + 1'b1;
            mode_d = ast_pkg::M_IDLE;
          end
        ast_pkg::M_HASH:
          if (is_dig(c)) begin
            if (len_d != '1) len_d = len_d + 1'b1;
            mode_d = ast_pkg::M_REG;
          end else if (c == ast_pkg::ChLf) begin
            if (line_d != '1) line_d = line_d + 1'b1;
            mode_d = ast_pkg::M_IDLE;
          end else mode_d = ast_pkg::M_COMMENT;
        ast_pkg::M_WORD:
          if (is_let(c) || is_dig(c)) begin
            if (len_q < NB'(KL)) begin
              for (int b = 0; b < KL; b++) begin
                if (len_q == NB'(b)) wbuf_d[8*b +: 8] = c;
              end
            end else ovl_d = 1'b1;
            if (len_d != '1) len_d = len_d + 1'b1;
          end else again = 1'b1;
        ast_pkg::M_NUMBER:
          if (is_dig(c)) begin
            if (len_d != '1) len_d = len_d + 1'b1;
          end else if (c == ast_pkg::ChDot) mode_d = ast_pkg::M_NUMDOT;
          else again = 1'b1;
        ast_pkg::M_NUMDOT:
          if (is_dig(c)) begin
            ls = {1'b0, len_q} + (NB+1)'(2);
            len_d = ls[NB] ? '1 : ls[NB-1:0];
            mode_d = ast_pkg::M_FRACTION;
          end else again = 1'b1;
        ast_pkg::M_FRACTION, ast_pkg::M_REG:
          if (is_dig(c)) begin
            if (len_d != '1) len_d = len_d + 1'b1;
          end else again = 1'b1;
        ast_pkg::M_LABEL:
          if (is_let(c) || is_dig(c)) begin
            if (len_d != '1) len_d = len_d + 1'b1;
          end else again = 1'b1;
        ast_pkg::M_STRING: begin
          if (len_d != '1) len_d = len_d + 1'b1;
          if (c == ast_pkg::ChQuote) begin
            nt[0] = '{kind: ast_pkg::K_STRING, kw: '0, start: start_q, len: len_d,
                      line: line_q, last: 1'b0};
            n = 3'd1;
            mode_d = ast_pkg::M_IDLE;
          end else if (c == ast_pkg::ChLf) begin
            if (line_d != '1) line_d = line_d + 1'b1;
          end
        end
        default: mode_d = ast_pkg::M_IDLE;
      endcase
    end
    if (again) begin
      es = {1'b0, start_q} + (OB+1)'(len_q);
      unique case (mode_q)
        ast_pkg::M_WORD: begin
          nt[0] = '{kind: (kw != '0) ? ast_pkg::K_KEYWORD : ast_pkg::K_WORD, kw: kw,
                    start: start_q, len: len_q, line: line_q, last: 1'b0};
          n = 3'd1;
        end
        ast_pkg::M_NUMBER, ast_pkg::M_FRACTION: begin
          nt[0] = '{kind: ast_pkg::K_NUMBER, kw: '0, start: start_q, len: len_q,
                    line: line_q, last: 1'b0};
          n = 3'd1;
        end
        ast_pkg::M_NUMDOT: begin
          nt[0] = '{kind: ast_pkg::K_NUMBER, kw: '0, start: start_q, len: len_q,
                    line: line_q, last: 1'b0};
          nt[1] = '{kind: ast_pkg::K_ERROR, kw: '0,
                    start: es[OB] ? '1 : es[OB-1:0], len: NB'(1), line: line_q, last: 1'b0};
          n = 3'd2;
        end
        ast_pkg::M_REG: begin
          nt[0] = '{kind: ast_pkg::K_REGISTER, kw: '0, start: start_q, len: len_q,
                    line: line_q, last: 1'b0};
          n = 3'd1;
        end
        ast_pkg::M_LABEL: begin
          nt[0] = '{kind: ast_pkg::K_LABEL, kw: '0, start: start_q, len: len_q,
                    line: line_q, last: 1'b0};
          n = 3'd1;
        end
        ast_pkg::M_STRING: begin
          nt[0] = '{kind: ast_pkg::K_STRING, kw: '0, start: start_q, len: len_q,
                    line: line_q, last: 1'b0};
          n = 3'd1;
        end
        default: ;
      endcase
      mode_d = ast_pkg::M_IDLE;
    end
    if (in_i.data.source_end) begin
      nt[n[1:0]] = '{kind: ast_pkg::K_END, kw: '0, start: pos_q, len: '0,
                     line: line_q, last: 1'b0};
      n = n + 3'd1;
      mode_d = ast_pkg::M_IDLE; pos_d = '0; line_d = '0;
    end else begin
      // Idle handling of the byte, first-byte of a token or a one-byte token.
      if (mode_q == ast_pkg::M_IDLE || again) begin
        if (c == ast_pkg::ChSpace || c == ast_pkg::ChTab || c == ast_pkg::ChCr) begin
        end else if (c == ast_pkg::ChLf) begin
          if (line_d != '1) line_d = line_d + 1'b1;
        end else if (c == ast_pkg::ChHash || is_let(c) || is_dig(c) ||
                     c == ast_pkg::ChColon || c == ast_pkg::ChQuote) begin
          start_d = pos_q; len_d = NB'(1);
          if (c == ast_pkg::ChHash) mode_d = ast_pkg::M_HASH;
          else if (is_let(c)) begin
            mode_d = ast_pkg::M_WORD; wbuf_d[7:0] = c; ovl_d = 1'b0;
          end else if (is_dig(c)) mode_d = ast_pkg::M_NUMBER;
          else if (c == ast_pkg::ChColon) mode_d = ast_pkg::M_LABEL;
          else mode_d = ast_pkg::M_STRING;
        end else begin
          nt[n[1:0]] = '{kind: (c == ast_pkg::ChComma) ? ast_pkg::K_COMMA : ast_pkg::K_ERROR,
                         kw: '0, start: pos_q, len: NB'(1), line: line_q, last: 1'b0};
          n = n + 3'd1;
        end
      end
      if (pos_q != '1) pos_d = pos_q + 1'b1;
    end
    // Tokens carry the line count from before this byte; mark the final one.
    for (int k = 0; k < 4; k++) begin
      nt[k].last = (3'(k) == n - 3'd1);
    end
  end

  // Result register: loaded on accept, drained one token per cycle while the receiver is ready.
  always_comb begin
    cnt_d = cnt_q; rd_d = rd_q;
    for (int k = 0; k < 4; k++) tok_d[k] = tok_q[k];
    if (pop) begin
      cnt_d = cnt_q - 3'd1; rd_d = rd_q + 2'd1;
    end
    if (fire) begin
      for (int k = 0; k < 4; k++) tok_d[k] = nt[k];
      cnt_d = n; rd_d = '0;
    end
  end

  assign out_o.data.token_kind    = tok_q[rd_q].kind;
  assign out_o.data.keyword_index = tok_q[rd_q].kw;
  assign out_o.data.start_offset  = tok_q[rd_q].start;
  assign out_o.data.token_length  = tok_q[rd_q].len;
  assign out_o.data.line_number   = tok_q[rd_q].line;
  assign out_o.data.last_of_run   = tok_q[rd_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ast_pkg::M_IDLE; start_q <= '0; pos_q <= '0; len_q <= '0;
      line_q <= '0; ovl_q <= 1'b0; cnt_q <= '0; rd_q <= '0;
    end else begin
      cnt_q <= cnt_d; rd_q <= rd_d;
      if (fire) begin
        mode_q <= mode_d; start_q <= start_d; pos_q <= pos_d; len_q <= len_d;
        line_q <= line_d; ovl_q <= ovl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) wbuf_q <= wbuf_d;
    for (int k = 0; k < 4; k++) tok_q[k] <= tok_d[k];
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("token count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q > 3'd1 |-> !in_i.ready) else $error("accept while tokens wait");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && cnt_q == 3'd1) |-> out_o.data.last_of_run)
    else $error("final token not marked");
  a_end_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.data.source_end) |=> (pos_q == '0 && mode_q == ast_pkg::M_IDLE))
    else $error("end did not restart");
`endif
endmodule

// ----- rtl/core/ast_kw_match.sv -----
module ast_kw_match (
  input  logic [ast_pkg::MaxKwLen*8-1:0]  word_i,
  input  logic [ast_pkg::LenBits-1:0]     len_i,
  input  logic                            overlong_i,
  output logic [ast_pkg::KwIdxBits-1:0]   kw_o
);
  logic [ast_pkg::MaxKwLen*8-1:0] mask;
  always_comb begin
    kw_o = '0;
    mask = '0;
    for (int b = 0; b < ast_pkg::MaxKwLen; b++) begin
      if (len_i > ast_pkg::LenBits'(b)) mask[8*b +: 8] = 8'hff;
    end
    if (!overlong_i && len_i <= ast_pkg::LenBits'(ast_pkg::MaxKwLen)) begin
      for (int i = ast_pkg::NumKw - 1; i >= 0; i--) begin
        if (len_i == ast_pkg::LenBits'(ast_pkg::kw_len(i)) &&
            (word_i & mask) == ast_pkg::kw_le(i)) begin
          kw_o = ast_pkg::KwIdxBits'(i + 1);
        end
      end
    end
  end
endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 20;

  // Token predictor plus the queue of tokens still owed by the block.
  class token_scoreboard;
    ast_pkg::token_t    owed[$];
    int                 errors;
    ast_pkg::mode_e     mode;
    logic [ast_pkg::OffBits-1:0]  tok_start;
    logic [ast_pkg::LenBits-1:0]  tok_len;
    logic [ast_pkg::LineBits-1:0] lines;
    logic [ast_pkg::OffBits-1:0]  pos;
    logic [7:0]                   wbuf[ast_pkg::MaxKwLen];
    bit                           overlong;
    ast_pkg::token_t              step_toks[$];
    string kw_names[ast_pkg::NumKw] = '{
      "nop", "exit", "peek", "poke", "memcpy", "goto", "jmpz", "jmpnz",
      "pop", "ret", "call", "push", "or", "xor", "add", "sub", "mul", "div",
      "inc", "dec", "and", "lft", "rgt", "not", "store", "random",
      {"print_", "int"}, "int2string", "concat", "system", {"print_", "str"},
      "string2int", "cmp", {"is_", "string"}, {"is_", "integer"}};

    function new();
      mode = ast_pkg::M_IDLE;
      tok_start = '0;
      tok_len = '0;
      lines = '0;
      pos = '0;
      overlong = 0;
      errors = 0;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void grow();
      if (tok_len != '1) tok_len++;
    endfunction

    function void next_line();
      if (lines != '1) lines++;
    endfunction

    function void push_tok(ast_pkg::kind_e k, int unsigned kw,
                           logic [ast_pkg::OffBits-1:0] s,
                           logic [ast_pkg::LenBits-1:0] l);
      ast_pkg::token_t t;
      t.kind  = k;
      t.kw    = ast_pkg::KwIdxBits'(kw);
      t.start = s;
      t.len   = l;
      t.line  = lines;
      t.last  = 1'b0;
      if (step_toks.size() < 4) step_toks.push_back(t);
    endfunction

    function int unsigned kw_lookup();
      bit hit;
      if (overlong || tok_len > ast_pkg::MaxKwLen) return 0;
      for (int i = 0; i < ast_pkg::NumKw; i++) begin
        hit = (kw_names[i].len() == tok_len);
        for (int j = 0; j < kw_names[i].len() && hit; j++)
          if (wbuf[j] != kw_names[i][j]) hit = 0;
        if (hit) return i + 1;
      end
      return 0;
    endfunction

    function void flush();
      int unsigned kw;
      logic [ast_pkg::OffBits:0] sum;
      case (mode)
        ast_pkg::M_WORD: begin
          kw = kw_lookup();
          push_tok(kw != 0 ? ast_pkg::K_KEYWORD : ast_pkg::K_WORD, kw, tok_start, tok_len);
        end
        ast_pkg::M_NUMBER, ast_pkg::M_FRACTION:
          push_tok(ast_pkg::K_NUMBER, 0, tok_start, tok_len);
        ast_pkg::M_NUMDOT: begin
          // dot with no digit after it: number, then the dot as an error
          push_tok(ast_pkg::K_NUMBER, 0, tok_start, tok_len);
          sum = tok_start + tok_len;
          push_tok(ast_pkg::K_ERROR, 0,
                   sum[ast_pkg::OffBits] ? '1 : sum[ast_pkg::OffBits-1:0], 1);
        end
        ast_pkg::M_REG:    push_tok(ast_pkg::K_REGISTER, 0, tok_start, tok_len);
        ast_pkg::M_LABEL:  push_tok(ast_pkg::K_LABEL, 0, tok_start, tok_len);
        ast_pkg::M_STRING: push_tok(ast_pkg::K_STRING, 0, tok_start, tok_len);
        default: ;
      endcase
      mode = ast_pkg::M_IDLE;
    endfunction

    function void open_tok(ast_pkg::mode_e m);
      mode = m;
      tok_start = pos;
      tok_len = 1;
    endfunction

    function void idle_byte(logic [7:0] c);
      if (c == ast_pkg::ChSpace || c == ast_pkg::ChTab || c == ast_pkg::ChCr) return;
      if (c == ast_pkg::ChLf) begin
        next_line();
        return;
      end
      if (c == ast_pkg::ChHash) open_tok(ast_pkg::M_HASH);
      else if (is_letter(c)) begin
        open_tok(ast_pkg::M_WORD);
        wbuf[0] = c;
        overlong = 0;
      end else if (is_num(c)) open_tok(ast_pkg::M_NUMBER);
      else if (c == ast_pkg::ChColon) open_tok(ast_pkg::M_LABEL);
      else if (c == ast_pkg::ChQuote) open_tok(ast_pkg::M_STRING);
      else push_tok(c == ast_pkg::ChComma ? ast_pkg::K_COMMA : ast_pkg::K_ERROR, 0, pos, 1);
    endfunction

    // Accepted input: work out the tokens it causes.
    function void note_byte(ast_pkg::src_item_t b);
      logic [7:0] c;
      bit again;
      c = b.char_in;
      again = 0;
      step_toks.delete();
      if (b.source_end) begin
        flush();
        push_tok(ast_pkg::K_END, 0, pos, 0);
        mode = ast_pkg::M_IDLE;
        pos = '0;
        lines = '0;
      end else begin
        case (mode)
          ast_pkg::M_COMMENT: if (c == ast_pkg::ChLf) begin
            next_line();
            mode = ast_pkg::M_IDLE;
          end
          ast_pkg::M_HASH: begin
            if (is_num(c)) begin
              grow();
              mode = ast_pkg::M_REG;
            end else if (c == ast_pkg::ChLf) begin
              next_line();
              mode = ast_pkg::M_IDLE;
            end else mode = ast_pkg::M_COMMENT;
          end
          ast_pkg::M_WORD: begin
            if (is_letter(c) || is_num(c)) begin
              if (tok_len < ast_pkg::MaxKwLen) wbuf[tok_len] = c;
              else overlong = 1;
              grow();
            end else again = 1;
          end
          ast_pkg::M_NUMBER: begin
            if (is_num(c)) grow();
            else if (c == ast_pkg::ChDot) mode = ast_pkg::M_NUMDOT;
            else again = 1;
          end
          ast_pkg::M_NUMDOT: begin
            if (is_num(c)) begin
              grow();
              grow();
              mode = ast_pkg::M_FRACTION;
            end else again = 1;
          end
          ast_pkg::M_FRACTION, ast_pkg::M_REG, ast_pkg::M_LABEL: begin
            if (is_num(c) || (mode == ast_pkg::M_LABEL && is_letter(c))) grow();
            else again = 1;
          end
          ast_pkg::M_STRING: begin
            grow();
            if (c == ast_pkg::ChQuote) begin
              push_tok(ast_pkg::K_STRING, 0, tok_start, tok_len);
              mode = ast_pkg::M_IDLE;
            end else if (c == ast_pkg::ChLf) next_line();
          end
          default: begin
            mode = ast_pkg::M_IDLE;
            idle_byte(c);
          end
        endcase
        if (again) begin
          flush();
          idle_byte(c);
        end
        if (pos != '1) pos++;
      end
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
      foreach (step_toks[i]) owed.push_back(step_toks[i]);
    endfunction

    function void check_token(ast_pkg::tok_item_t got);
      ast_pkg::token_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected token kind=%0d start=%0d", $realtime,
                 got.token_kind, got.start_offset);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.token_kind != want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $realtime, want.kind,
                 got.token_kind);
        errors++;
      end
      if (got.keyword_index != want.kw) begin
        $display("%0t: keyword expected %0d actual %0d", $realtime, want.kw,
                 got.keyword_index);
        errors++;
      end
      if (got.start_offset != want.start) begin
        $display("%0t: start expected %0d actual %0d", $realtime, want.start,
                 got.start_offset);
        errors++;
      end
      if (got.token_length != want.len) begin
        $display("%0t: length expected %0d actual %0d", $realtime, want.len,
                 got.token_length);
        errors++;
      end
      if (got.line_number != want.line) begin
        $display("%0t: line expected %0d actual %0d", $realtime, want.line,
                 got.line_number);
        errors++;
      end
      if (got.last_of_run != want.last) begin
        $display("%0t: last expected %0b actual %0b", $realtime, want.last,
                 got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ast_stream_if #(.T(ast_pkg::src_item_t)) src_if ();
  ast_stream_if #(.T(ast_pkg::tok_item_t)) tok_if ();

  assembly_source_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (src_if.sink),
    .out_o  (tok_if.source)
  );

  token_scoreboard sb;
  int unsigned src_idle;   // percent of cycles the sender idles
  int unsigned snk_idle;   // percent of cycles the receiver stalls
  int unsigned hold_req;   // long receiver hold-off, in cycles
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Monitor: check results first; tokens of this edge's byte come later.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tok_if.valid && tok_if.ready) sb.check_token(tok_if.data);
      if (src_if.valid && src_if.ready) sb.note_byte(src_if.data);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned held;
    tok_if.ready = 1'b0;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        tok_if.ready <= 1'b0;
        held++;
        if (held >= hold_req) begin
          hold_req = 0;
          held = 0;
        end
      end else begin
        tok_if.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // Offer one byte; called at a falling edge and returns at one.
  task automatic send_byte(logic [7:0] c, logic e);
    ast_pkg::src_item_t b;
    while ($urandom_range(99) < src_idle) begin
      src_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    b.char_in = c;
    b.source_end = e;
    src_if.valid <= 1'b1;
    src_if.data <= b;
    do @(posedge clk_i); while (!src_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic end_source();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  // One well-formed fragment with random content, or a noise byte.
  task automatic send_fragment();
    int unsigned n;
    case ($urandom_range(11))
      0, 1: send_text(sb.kw_names[$urandom_range(ast_pkg::NumKw-1)]);
      2: begin
        n = $urandom_range(1, 14);
        send_byte(rand_letter(), 1'b0);
        repeat (n - 1) send_byte($urandom_range(3) == 0 ? rand_digit() : rand_letter(),
                                 1'b0);
      end
      3: begin
        repeat ($urandom_range(1, 5)) send_byte(rand_digit(), 1'b0);
        if ($urandom_range(1)) begin
          send_byte(ast_pkg::ChDot, 1'b0);
          repeat ($urandom_range(0, 3)) send_byte(rand_digit(), 1'b0);
        end
      end
      4: begin
        send_byte(ast_pkg::ChHash, 1'b0);
        repeat ($urandom_range(1, 3)) send_byte(rand_digit(), 1'b0);
      end
      5: begin
        send_byte(ast_pkg::ChColon, 1'b0);
        repeat ($urandom_range(0, 6)) send_byte(rand_letter(), 1'b0);
      end
      6: send_byte(ast_pkg::ChComma, 1'b0);
      7: begin
        send_byte(ast_pkg::ChQuote, 1'b0);
        repeat ($urandom_range(0, 6))
          send_byte($urandom_range(4) == 0 ? ast_pkg::ChLf : rand_letter(), 1'b0);
        send_byte(ast_pkg::ChQuote, 1'b0);
      end
      8: begin
        send_byte(ast_pkg::ChHash, 1'b0);
        repeat ($urandom_range(0, 6)) send_byte(rand_letter(), 1'b0);
        send_byte(ast_pkg::ChLf, 1'b0);
      end
      default: send_byte(8'($urandom_range(255)), 1'b0);
    endcase
    // separator, sometimes none so tokens butt together
    case ($urandom_range(5))
      0: send_byte(ast_pkg::ChSpace, 1'b0);
      1: send_byte(ast_pkg::ChLf, 1'b0);
      2: send_byte(ast_pkg::ChTab, 1'b0);
      3: send_byte(ast_pkg::ChCr, 1'b0);
      4: send_byte(ast_pkg::ChComma, 1'b0);
      default: ;
    endcase
  endtask

  // Roughly nbytes bytes: a fragment plus separator averages about five.
  task automatic random_phase(int unsigned nbytes);
    for (int i = 0; i < nbytes / 5; i++) begin
      send_fragment();
      if ($urandom_range(29) == 0) end_source();
    end
  endtask

  task automatic wait_drained();
    src_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    src_idle = 0;
    snk_idle = 0;
    hold_req = 0;
    src_if.valid = 1'b0;
    src_if.data = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: keywords, long word, dot without digit, lone hash and colon,
    // register, zero byte, LF inside a string, then a trailing dot and a lone hash at the end.
    send_text("nop memcpy is_");
    send_text("integer\n");
    send_text("int2stringx 12.5 7.x #3,# c\n:lb1 : ");
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("\"a\nb\"\"op");
    end_source();
    send_text("12.");
    end_source();
    send_text("#");
    end_source();
    wait_drained();

    // Receiver stalls more than the sender idles.
    src_idle = 28;
    snk_idle = 58;
    random_phase(130);
    // Long receiver hold-off while bytes keep coming.
    hold_req = 300;
    src_idle = 0;
    random_phase(40);
    wait_drained();

    src_idle = 58;
    snk_idle = 28;
    random_phase(130);
    wait_drained();

    src_idle = 0;
    snk_idle = 0;
    random_phase(130);
    end_source();

    wait_drained();
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
